/* hw/rtl/dgps_pkg.sv */
// Shared types, register codes, constants and small helper functions for the
// dither gradient pixel shader. Depends on nothing; used by every RTL file.
package dgps_pkg;

    // Register indexes on the configuration write channel.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_LEFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_COLOR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCENT_COLOR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 3'd7;

    // Fill mode codes.
    localparam logic [4:0] MODE_LAST_FIXED  = 5'd12;
    localparam logic [4:0] MODE_GRAD_TOP    = 5'd13;
    localparam logic [4:0] MODE_GRAD_BOTTOM = 5'd14;
    localparam logic [4:0] MODE_GRAD_LEFT   = 5'd15;
    localparam logic [4:0] MODE_GRAD_RIGHT  = 5'd16;

    // Coverage level codes (0, 10, 20, 25, 30, 40, 50 ... 100 percent).
    localparam logic [3:0] LVL_0    = 4'd0;
    localparam logic [3:0] LVL_10   = 4'd1;
    localparam logic [3:0] LVL_20   = 4'd2;
    localparam logic [3:0] LVL_25   = 4'd3;
    localparam logic [3:0] LVL_30   = 4'd4;
    localparam logic [3:0] LVL_40   = 4'd5;
    localparam logic [3:0] LVL_HALF = 4'd6;
    localparam logic [3:0] LVL_60   = 4'd7;
    localparam logic [3:0] LVL_70   = 4'd8;
    localparam logic [3:0] LVL_75   = 4'd9;
    localparam logic [3:0] LVL_80   = 4'd10;
    localparam logic [3:0] LVL_90   = 4'd11;
    localparam logic [3:0] LVL_FULL = 4'd12;

    // Gradient band geometry.
    localparam int unsigned BANDS_FINE   = 11;
    localparam int unsigned BANDS_COARSE = 5;
    localparam logic [8:0]  FINE_MIN_EXTENT = 9'd55;

    // Default screen limits.
    localparam int unsigned SCREEN_MAX_X_DEF = 143;
    localparam int unsigned SCREEN_MAX_Y_DEF = 167;

    typedef struct packed {
        logic [4:0]        fill_mode;
        logic signed [9:0] rect_left;
        logic signed [9:0] rect_top;
        logic [8:0]        rect_width;
        logic [8:0]        rect_height;
        logic [7:0]        base_color;
        logic [7:0]        accent_color;
        logic [8:0]        row_stride;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        fill_mode:    5'd0,
        rect_left:    10'sd0,
        rect_top:     10'sd0,
        rect_width:   9'd0,
        rect_height:  9'd0,
        base_color:   8'd0,
        accent_color: 8'd0,
        row_stride:   9'd144
    };

    // Coverage decision for one pixel: whether it is drawn, at which level,
    // and whether the gradient direction exchanges the two colors.
    typedef struct packed {
        logic       hit;
        logic [3:0] level;
        logic       swap;
    } t_cover;

    // Extent divided by 11, exact for every 9-bit value (reciprocal 745/8192).
    function automatic logic [8:0] div11(input logic [8:0] e);
        logic [18:0] prod;
        prod = 19'(e) * 19'd745;
        return {3'b000, prod[18:13]};
    endfunction

    // Extent divided by 5, exact for extents below the fine threshold
    // (reciprocal 1639/8192).
    function automatic logic [8:0] div5(input logic [8:0] e);
        logic [18:0] prod;
        prod = 19'(e) * 19'd1639;
        return {3'b000, prod[18:13]};
    endfunction

    // Level of band k when the extent is cut into eleven 10% bands.
    function automatic logic [3:0] fine_band_level(input logic [3:0] k);
        logic [3:0] lvl;
        case (k)
            4'd0:    lvl = LVL_0;
            4'd1:    lvl = LVL_10;
            4'd2:    lvl = LVL_20;
            4'd3:    lvl = LVL_30;
            4'd4:    lvl = LVL_40;
            4'd5:    lvl = LVL_HALF;
            4'd6:    lvl = LVL_60;
            4'd7:    lvl = LVL_70;
            4'd8:    lvl = LVL_80;
            4'd9:    lvl = LVL_90;
            4'd10:   lvl = LVL_FULL;
            default: lvl = LVL_0;
        endcase
        return lvl;
    endfunction

    // Level of band k when the extent is cut into five 25% bands.
    function automatic logic [3:0] coarse_band_level(input logic [3:0] k);
        logic [3:0] lvl;
        case (k)
            4'd0:    lvl = LVL_0;
            4'd1:    lvl = LVL_25;
            4'd2:    lvl = LVL_HALF;
            4'd3:    lvl = LVL_75;
            4'd4:    lvl = LVL_FULL;
            default: lvl = LVL_0;
        endcase
        return lvl;
    endfunction

endpackage

/* hw/rtl/dgps_cover.sv */
// Rectangle and gradient band coverage for one pixel coordinate.
// Depends on dgps_pkg.
module dgps_cover (
    input  logic signed [10:0] i_x,
    input  logic signed [10:0] i_y,
    input  dgps_pkg::t_cfg     i_cfg,
    output dgps_pkg::t_cover   o_cover
);
    import dgps_pkg::*;

    logic signed [12:0] x_s, y_s;
    logic signed [12:0] left_s, top_s, right_s, bottom_s;
    logic               in_x, in_y;
    logic               vert, swap, in_cross, fine;
    logic [8:0]         ext;
    logic signed [12:0] org_s, pos_s, d_s;
    logic [8:0]         len;
    logic signed [17:0] d1_s, dlen_s, lo_lim, hi_lim;
    logic signed [17:0] band_ke [BANDS_FINE];
    logic [BANDS_FINE-1:0] band_hit;
    logic [3:0]         sel;
    logic               found;

    assign x_s      = {{2{i_x[10]}}, i_x};
    assign y_s      = {{2{i_y[10]}}, i_y};
    assign left_s   = {{3{i_cfg.rect_left[9]}}, i_cfg.rect_left};
    assign top_s    = {{3{i_cfg.rect_top[9]}}, i_cfg.rect_top};
    assign right_s  = left_s + $signed({4'b0000, i_cfg.rect_width});
    assign bottom_s = top_s + $signed({4'b0000, i_cfg.rect_height});
    assign in_x     = (x_s >= left_s) && (x_s < right_s);
    assign in_y     = (y_s >= top_s) && (y_s < bottom_s);

    assign vert  = (i_cfg.fill_mode == MODE_GRAD_TOP) || (i_cfg.fill_mode == MODE_GRAD_BOTTOM);
    assign swap  = (i_cfg.fill_mode == MODE_GRAD_BOTTOM) || (i_cfg.fill_mode == MODE_GRAD_RIGHT);
    assign ext   = vert ? i_cfg.rect_height : i_cfg.rect_width;
    assign org_s = vert ? top_s : left_s;
    assign pos_s = vert ? y_s : x_s;
    assign in_cross = vert ? in_x : in_y;
    assign fine  = ext >= FINE_MIN_EXTENT;
    assign d_s   = pos_s - org_s;
    assign len   = 9'd1 + (fine ? div11(ext) : div5(ext));

    // Band k covers offset d when floor(k*E/n) <= d < floor(k*E/n) + len.
    // Both sides are compared after scaling by n, so no per-band divide.
    assign d1_s   = {{5{d_s[12]}}, d_s} + 18'sd1;
    assign dlen_s = d1_s - $signed({9'b0, len});
    assign lo_lim = fine ? d1_s * 18'sd11 : d1_s * 18'sd5;
    assign hi_lim = fine ? dlen_s * 18'sd11 : dlen_s * 18'sd5;

    for (genvar k = 0; k < BANDS_FINE; k++) begin : g_band
        logic band_used;
        assign band_used   = fine || (k < BANDS_COARSE);
        assign band_ke[k]  = $signed(18'(ext) * 18'(k));
        assign band_hit[k] = band_used && !d_s[12] && (band_ke[k] < lo_lim)
                             && (hi_lim <= band_ke[k]);
    end

    // The highest covering band wins.
    always_comb begin
        sel   = 4'd0;
        found = 1'b0;
        for (int k = 0; k < BANDS_FINE; k++) begin
            if (band_hit[k]) begin
                sel   = 4'(k);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        o_cover = '0;
        if (i_cfg.fill_mode <= MODE_LAST_FIXED) begin
            o_cover.hit   = in_x && in_y;
            o_cover.level = i_cfg.fill_mode[3:0];
        end else if (i_cfg.fill_mode <= MODE_GRAD_RIGHT) begin
            o_cover.hit   = in_cross && found;
            o_cover.level = fine ? fine_band_level(sel) : coarse_band_level(sel);
            o_cover.swap  = swap;
        end
    end

endmodule

/* hw/rtl/dgps_pattern.sv */
// Ordered-dither pattern lookup: picks one of the two colors for a pixel
// from its coverage level and the low bits of its coordinates. Depends on dgps_pkg.
module dgps_pattern (
    input  logic [3:0] i_level,
    input  logic       i_swap,
    input  logic [7:0] i_base_color,
    input  logic [7:0] i_accent_color,
    input  logic [2:0] i_x3,
    input  logic [2:0] i_y3,
    output logic [7:0] o_color
);
    import dgps_pkg::*;

    logic       upper;
    logic       flip;
    logic [3:0] lvl;
    logic [2:0] xp4, xp2, yp2, yp1, s3;
    logic       second;
    logic [7:0] first_c, second_c;

    // Levels above one half use the mirrored pattern with colors exchanged.
    assign upper = i_level > LVL_HALF;
    assign lvl   = upper ? (LVL_FULL - i_level) : i_level;
    assign flip  = upper ^ i_swap;
    assign first_c  = flip ? i_accent_color : i_base_color;
    assign second_c = flip ? i_base_color : i_accent_color;

    assign xp4 = i_x3 + 3'd4;
    assign xp2 = i_x3 + 3'd2;
    assign yp2 = i_y3 + 3'd2;
    assign yp1 = i_y3 + 3'd1;
    assign s3  = i_x3 + i_y3;

    always_comb begin
        case (lvl)
            LVL_10:   second = (i_x3 == 3'd0 && i_y3[1:0] == 2'd0) ||
                               (xp4 == 3'd0 && yp2[1:0] == 2'd0);
            LVL_20:   second = (i_x3[1:0] == 2'd0 && i_y3[1:0] == 2'd0) ||
                               (xp2[1:0] == 2'd0 && yp2[1:0] == 2'd0);
            LVL_25:   second = (i_x3[1:0] == 2'd0 && !i_y3[0]) ||
                               (xp2[1:0] == 2'd0 && !yp1[0]);
            LVL_30:   second = !s3[0] && (s3[1:0] != 2'd0 || (i_x3[0] && i_y3[0]));
            LVL_40:   second = !s3[0] && (s3 != 3'd0 ||
                               (i_x3[1:0] != 2'd1 && i_y3[1:0] != 2'd3));
            LVL_HALF: second = !s3[0];
            default:  second = 1'b0;
        endcase
    end

    assign o_color = second ? second_c : first_c;

endmodule

/* hw/rtl/dither_gradient_pixel_shader_top.sv */
// Top level of the dither gradient pixel shader: configuration registers,
// input register, screen clip, address multiply and result register.
// Depends on dgps_pkg, dgps_cover and dgps_pattern.
//
//  Channel   Direction  Handshake                      Beat carries
//  pixel     in         start high and busy low        i_pixel_x, i_pixel_y
//  result    out        o_result_valid for one cycle   o_write_enable, o_byte_address,
//                                                      o_pixel_color
//  config    in         i_cfg_valid and o_cfg_ready    i_cfg_index, i_cfg_data
//
// A pixel beat can be taken in every cycle while busy is low. The accepted beat loads the input
// register, and the result register then loads from the coverage, pattern and address
// logic, so the strobe is high once the result register holds the beat.
// The reset is synchronous and active low; busy and o_cfg_ready stay in
// their blocked state for the cycle of reset itself and are released after.
// The result side has no back pressure, so the pipeline never stalls.
// Configuration must only be written while no pixel is in flight.
module dither_gradient_pixel_shader_top #(
    parameter int unsigned SCREEN_MAX_X = dgps_pkg::SCREEN_MAX_X_DEF,
    parameter int unsigned SCREEN_MAX_Y = dgps_pkg::SCREEN_MAX_Y_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [10:0]                 i_pixel_x,
    input  logic signed [10:0]                 i_pixel_y,
    output logic                               o_result_valid,
    output logic                               o_write_enable,
    output logic [15:0]                        o_byte_address,
    output logic [7:0]                         o_pixel_color,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dgps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dgps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dgps_pkg::*;

    localparam logic signed [12:0] MAX_X_S = 13'(SCREEN_MAX_X);
    localparam logic signed [12:0] MAX_Y_S = 13'(SCREEN_MAX_Y);

    logic               r_rst_busy;
    t_cfg               r_cfg;
    logic               in_accept;
    logic               r_in_vld;
    logic signed [10:0] r_x, r_y;

    logic               r_out_vld;
    logic               r_we;
    logic [15:0]        r_addr;
    logic [7:0]         r_color;
    logic               n_we;
    logic [15:0]        n_addr;
    logic [7:0]         n_color;

    logic signed [12:0] x_s, y_s;
    logic               on_screen;
    t_cover             pix_cov;
    logic [7:0]         shade;
    logic [18:0]        addr_full;

    // Held high only across reset so no beat is taken then.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_busy <= 1'b1;
        end else begin
            r_rst_busy <= 1'b0;
        end
    end

    assign busy        = r_rst_busy;
    assign o_cfg_ready = !r_rst_busy;
    assign in_accept   = start && !busy;

    // Configuration registers. Each write keeps only the bits the register holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FILL_MODE:    r_cfg.fill_mode    <= i_cfg_data[4:0];
                CFG_RECT_LEFT:    r_cfg.rect_left    <= $signed(i_cfg_data[9:0]);
                CFG_RECT_TOP:     r_cfg.rect_top     <= $signed(i_cfg_data[9:0]);
                CFG_RECT_WIDTH:   r_cfg.rect_width   <= i_cfg_data[8:0];
                CFG_RECT_HEIGHT:  r_cfg.rect_height  <= i_cfg_data[8:0];
                CFG_BASE_COLOR:   r_cfg.base_color   <= i_cfg_data[7:0];
                CFG_ACCENT_COLOR: r_cfg.accent_color <= i_cfg_data[7:0];
                CFG_ROW_STRIDE:   r_cfg.row_stride   <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x <= i_pixel_x;
            r_y <= i_pixel_y;
        end
    end

    // Screen clip on the registered coordinate.
    assign x_s = {{2{r_x[10]}}, r_x};
    assign y_s = {{2{r_y[10]}}, r_y};
    assign on_screen = !r_x[10] && !r_y[10] && (x_s <= MAX_X_S) && (y_s <= MAX_Y_S);

    dgps_cover u_cover (
        .i_x     (r_x),
        .i_y     (r_y),
        .i_cfg   (r_cfg),
        .o_cover (pix_cov)
    );

    dgps_pattern u_pattern (
        .i_level        (pix_cov.level),
        .i_swap         (pix_cov.swap),
        .i_base_color   (r_cfg.base_color),
        .i_accent_color (r_cfg.accent_color),
        .i_x3           (r_x[2:0]),
        .i_y3           (r_y[2:0]),
        .o_color        (shade)
    );

    // Byte address: row times stride plus column, kept modulo 2^16. Only
    // on-screen pixels are written, so both coordinates are nonnegative here.
    assign addr_full = 19'(r_y[9:0]) * 19'(r_cfg.row_stride) + 19'(r_x[9:0]);

    // A pixel that is not written carries zero address and zero color.
    always_comb begin
        n_we    = on_screen && pix_cov.hit;
        n_addr  = n_we ? addr_full[15:0] : 16'd0;
        n_color = n_we ? shade : 8'd0;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_we    <= n_we;
        r_addr  <= n_addr;
        r_color <= n_color;
    end

    assign o_result_valid = r_out_vld;
    assign o_write_enable = r_we;
    assign o_byte_address = r_addr;
    assign o_pixel_color  = r_color;

    // Every accepted beat enters the input stage and moves to the output stage.
    a_accept_to_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_in_vld)
        else $error("accepted pixel did not enter the input stage");

    a_stage_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> o_result_valid)
        else $error("input stage did not produce a result");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_in_vld))
        else $error("result strobe without a pixel in the input stage");

    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_write_enable) |->
            (o_byte_address == 16'd0 && o_pixel_color == 8'd0))
        else $error("unwritten pixel carries a nonzero address or color");

    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (!busy && o_cfg_ready))
        else $error("block still blocked after reset release");

endmodule

/* verif/dither_gradient_pixel_shader_top_tb.sv */
// Self-checking testbench for dither_gradient_pixel_shader_top: directed and random fills
// compared against an in-bench shading predictor. Depends on dgps_pkg and the RTL top level.
`timescale 1ns / 100ps

module dither_gradient_pixel_shader_top_tb;
    import dgps_pkg::*;

    // One shaded pixel as it leaves the block.
    typedef struct packed {
        logic        write_enable;
        logic [15:0] byte_address;
        logic [7:0]  pixel_color;
    } t_pixel_write;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_CAP   = 40;
    localparam int SETTLE      = 4;     // two-stage pipeline plus margin
    localparam int RANDOM_BEATS = 550;

    // Band geometry: start of band k is floor(step * k * extent / den).
    localparam int FINE_STEP   = 10;
    localparam int FINE_DEN    = 110;
    localparam int COARSE_STEP = 25;
    localparam int COARSE_DEN  = 125;
    localparam int FINE_DIV    = 11;
    localparam int COARSE_DIV  = 5;

    localparam int FINE_LEVELS [11] = '{LVL_0, LVL_10, LVL_20, LVL_30, LVL_40, LVL_HALF,
                                        LVL_60, LVL_70, LVL_80, LVL_90, LVL_FULL};
    localparam int COARSE_LEVELS [5] = '{LVL_0, LVL_25, LVL_HALF, LVL_75, LVL_FULL};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic signed [10:0]    i_pixel_x;
    logic signed [10:0]    i_pixel_y;
    logic                  o_result_valid;
    logic                  o_write_enable;
    logic [15:0]           o_byte_address;
    logic [7:0]            o_pixel_color;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // The predictor's copy of the register file, updated on each accepted write beat.
    t_cfg         fill_cfg;
    t_pixel_write expected_writes[$];
    int           err_count;
    int           cycle_count;
    int           pixels_sent;
    int           pixel_gap_pct;   // chance in percent of an idle gap before a pixel beat

    dither_gradient_pixel_shader_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_result_valid (o_result_valid),
        .o_write_enable (o_write_enable),
        .o_byte_address (o_byte_address),
        .o_pixel_color  (o_pixel_color),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shading predictor
    // ------------------------------------------------------------------

    // Ordered-dither pattern for levels up to one half; true picks the second color.
    function automatic bit dither_on(int lvl, int x, int y);
        int s;
        s = x + y;
        case (lvl)
            LVL_10:   return (x % 8 == 0 && y % 4 == 0) ||
                             ((x + 4) % 8 == 0 && (y + 2) % 4 == 0);
            LVL_20:   return (x % 4 == 0 && y % 4 == 0) ||
                             ((x + 2) % 4 == 0 && (y + 2) % 4 == 0);
            LVL_25:   return (x % 4 == 0 && y % 2 == 0) ||
                             ((x + 2) % 4 == 0 && (y + 1) % 2 == 0);
            LVL_30:   return s % 2 == 0 && (s % 4 != 0 || (x % 2 != 0 && y % 2 != 0));
            LVL_40:   return s % 2 == 0 && (s % 8 != 0 || (x % 4 != 1 && y % 4 != 3));
            LVL_HALF: return s % 2 == 0;
            default:  return 1'b0;
        endcase
    endfunction

    // Levels above one half mirror the pattern and trade the two colors.
    function automatic logic [7:0] dither_color(int lvl, logic [7:0] first,
                                                logic [7:0] second, int x, int y);
        logic [7:0] tmp;
        if (lvl > LVL_HALF) begin
            tmp = first;
            first = second;
            second = tmp;
            lvl = LVL_FULL - lvl;
        end
        return dither_on(lvl, x, y) ? second : first;
    endfunction

    function automatic t_pixel_write predict_pixel_write(logic signed [10:0] px,
                                                         logic signed [10:0] py, t_cfg c);
        int           x, y, l, t, w, h, m;
        int           ext, org, pos, n, den, stp, len, st, lvl;
        bit           vert, swap, in_cross, hit;
        logic [7:0]   first, second, color;
        t_pixel_write r;
        x = px;
        y = py;
        l = $signed(c.rect_left);
        t = $signed(c.rect_top);
        w = int'(c.rect_width);
        h = int'(c.rect_height);
        m = int'(c.fill_mode);
        hit = 1'b0;
        color = 8'd0;
        r = '0;
        if (x < 0 || x > SCREEN_MAX_X_DEF || y < 0 || y > SCREEN_MAX_Y_DEF)
            return r;

        if (m <= MODE_LAST_FIXED) begin
            if (x >= l && x < l + w && y >= t && y < t + h) begin
                hit = 1'b1;
                color = dither_color(m, c.base_color, c.accent_color, x, y);
            end
        end else if (m <= MODE_GRAD_RIGHT) begin
            vert   = (m <= MODE_GRAD_BOTTOM);
            swap   = (m == MODE_GRAD_BOTTOM || m == MODE_GRAD_RIGHT);
            first  = swap ? c.accent_color : c.base_color;
            second = swap ? c.base_color : c.accent_color;
            ext    = vert ? h : w;
            org    = vert ? t : l;
            pos    = vert ? y : x;
            in_cross = vert ? (x >= l && x < l + w) : (y >= t && y < t + h);
            if (in_cross) begin
                if (ext >= FINE_MIN_EXTENT) begin
                    n = BANDS_FINE; den = FINE_DEN; stp = FINE_STEP;
                    len = 1 + ext / FINE_DIV;
                end else begin
                    n = BANDS_COARSE; den = COARSE_DEN; stp = COARSE_STEP;
                    len = 1 + ext / COARSE_DIV;
                end
                // The highest band that covers the pixel decides its level.
                for (int k = n - 1; k >= 0 && !hit; k--) begin
                    st = org + (stp * k * ext) / den;
                    if (pos >= st && pos < st + len) begin
                        lvl = (n == BANDS_FINE) ? FINE_LEVELS[k] : COARSE_LEVELS[k];
                        hit = 1'b1;
                        color = dither_color(lvl, first, second, x, y);
                    end
                end
            end
        end

        if (hit) begin
            r.write_enable = 1'b1;
            r.byte_address = 16'(y * int'(c.row_stride) + x);
            r.pixel_color  = color;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting, drive and check
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        if (err_count < PRINT_CAP)
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Every result beat is checked field by field against the oldest prediction.
    // The result port has no back pressure, so the strobe alone marks a beat.
    always @(posedge i_clk) begin
        t_pixel_write want;
        if (i_rst_n && o_result_valid) begin
            if (expected_writes.size() == 0) begin
                report_mismatch("result beat with no pixel pending", 1, 0);
            end else begin
                want = expected_writes.pop_front();
                if (o_write_enable !== want.write_enable)
                    report_mismatch("write_enable", o_write_enable, want.write_enable);
                if (o_byte_address !== want.byte_address)
                    report_mismatch("byte_address", o_byte_address, want.byte_address);
                if (o_pixel_color !== want.pixel_color)
                    report_mismatch("pixel_color", o_pixel_color, want.pixel_color);
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Random data above the field width checks that the register ignores those bits.
    function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned v, int width);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        for (int i = 0; i < width; i++)
            d[i] = v[i];
        return d;
    endfunction

    // One configuration beat. Called right after a rising edge; valid may stay high
    // into the next write, and the caller lowers it once the last beat is taken.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FILL_MODE:    fill_cfg.fill_mode    = data[4:0];
            CFG_RECT_LEFT:    fill_cfg.rect_left    = data[9:0];
            CFG_RECT_TOP:     fill_cfg.rect_top     = data[9:0];
            CFG_RECT_WIDTH:   fill_cfg.rect_width   = data[8:0];
            CFG_RECT_HEIGHT:  fill_cfg.rect_height  = data[8:0];
            CFG_BASE_COLOR:   fill_cfg.base_color   = data[7:0];
            CFG_ACCENT_COLOR: fill_cfg.accent_color = data[7:0];
            CFG_ROW_STRIDE:   fill_cfg.row_stride   = data[8:0];
            default: ;
        endcase
    endtask

    // Writes the whole register file. The block must be idle: see wait_pixels_done.
    task automatic load_config(t_cfg c);
        cfg_write(CFG_FILL_MODE,    with_junk(c.fill_mode, 5));
        cfg_write(CFG_RECT_LEFT,    with_junk(c.rect_left, 10));
        cfg_write(CFG_RECT_TOP,     with_junk(c.rect_top, 10));
        cfg_write(CFG_RECT_WIDTH,   with_junk(c.rect_width, 9));
        cfg_write(CFG_RECT_HEIGHT,  with_junk(c.rect_height, 9));
        cfg_write(CFG_BASE_COLOR,   with_junk(c.base_color, 8));
        cfg_write(CFG_ACCENT_COLOR, with_junk(c.accent_color, 8));
        cfg_write(CFG_ROW_STRIDE,   with_junk(c.row_stride, 9));
        i_cfg_valid <= 1'b0;
    endtask

    // Sends one pixel beat, possibly after a random idle gap. With no gap, start
    // stays high from the previous beat so the block sees back-to-back pixels.
    task automatic shade_pixel(logic signed [10:0] x, logic signed [10:0] y);
        if ($urandom_range(99) < pixel_gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        do @(posedge i_clk); while (busy);
        expected_writes.push_back(predict_pixel_write(x, y, fill_cfg));
        pixels_sent++;
    endtask

    // Holds the sender off until every pixel in flight has produced its result.
    task automatic wait_pixels_done();
        start <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers give an empty rectangle, so nothing is written.
    task automatic test_reset_state();
        pixel_gap_pct = 0;
        shade_pixel(11'sd0, 11'sd0);
        shade_pixel(11'sd143, 11'sd167);
        wait_pixels_done();
    endtask

    // Full coverage on a rectangle larger than the screen; pixels on and just
    // past every screen edge, plus the most negative and most positive coordinates.
    task automatic test_screen_clip();
        t_cfg c;
        c = CFG_RESET;
        c.fill_mode = MODE_LAST_FIXED;
        c.rect_width = 9'd511;
        c.rect_height = 9'd511;
        c.base_color = 8'hFF;
        c.accent_color = 8'h5A;
        c.row_stride = 9'd256;
        load_config(c);
        shade_pixel(11'sd0, 11'sd0);
        shade_pixel(11'sd143, 11'sd167);
        shade_pixel(11'sd144, 11'sd0);
        shade_pixel(11'sd0, 11'sd168);
        shade_pixel(-11'sd1, 11'sd5);
        shade_pixel(11'sd5, -11'sd1);
        shade_pixel(-11'sd1024, -11'sd1024);
        shade_pixel(11'sd1023, 11'sd1023);
        wait_pixels_done();
    endtask

    // Gradient band corner cases: a zero extent still gives one-pixel bands, and
    // the fine split lets its last band reach one column past the rectangle.
    task automatic test_band_edges();
        t_cfg c;
        c = CFG_RESET;
        c.fill_mode = MODE_GRAD_TOP;
        c.rect_top = 10'sd10;
        c.rect_width = 9'd144;
        c.base_color = 8'h11;
        c.accent_color = 8'hEE;
        load_config(c);
        shade_pixel(11'sd5, 11'sd9);
        shade_pixel(11'sd5, 11'sd10);
        shade_pixel(11'sd5, 11'sd11);
        wait_pixels_done();

        // Coarse split just below the threshold; the last band stops inside.
        c.rect_height = 9'd54;
        c.fill_mode = MODE_GRAD_BOTTOM;
        load_config(c);
        shade_pixel(11'sd6, 11'sd63);
        shade_pixel(11'sd6, 11'sd64);
        wait_pixels_done();

        // Fine split at the threshold; one column past the right edge is still written.
        c.fill_mode = MODE_GRAD_RIGHT;
        c.rect_left = 10'sd20;
        c.rect_width = 9'd55;
        c.rect_top = 10'sd0;
        c.rect_height = 9'd100;
        load_config(c);
        shade_pixel(11'sd75, 11'sd3);
        shade_pixel(11'sd76, 11'sd3);
        wait_pixels_done();
    endtask

    // Stride of zero and of 511 (address wraps), then the unused fill modes.
    task automatic test_odd_stride_and_modes();
        t_cfg c;
        c = CFG_RESET;
        c.fill_mode = MODE_GRAD_LEFT;
        c.rect_width = 9'd144;
        c.rect_height = 9'd168;
        c.accent_color = 8'h80;
        c.row_stride = 9'd0;
        load_config(c);
        shade_pixel(11'sd100, 11'sd100);
        wait_pixels_done();
        c.row_stride = 9'd511;
        load_config(c);
        shade_pixel(11'sd143, 11'sd167);
        wait_pixels_done();
        c.fill_mode = 5'd31;
        load_config(c);
        shade_pixel(11'sd10, 11'sd10);
        wait_pixels_done();
        c.fill_mode = MODE_GRAD_RIGHT + 5'd1;
        load_config(c);
        shade_pixel(11'sd10, 11'sd10);
        wait_pixels_done();
    endtask

    function automatic t_cfg random_fill_config();
        t_cfg c;
        int   pick;
        c.fill_mode = ($urandom_range(99) < 8) ? 5'($urandom_range(17, 31))
                                               : 5'($urandom_range(0, 16));
        pick = $urandom_range(99);
        c.rect_left = (pick < 5) ? -10'sd512 : (pick < 10) ? 10'sd511 :
                      (pick < 22) ? 10'($urandom) : 10'($urandom_range(0, 180) - 30);
        pick = $urandom_range(99);
        c.rect_top = (pick < 5) ? -10'sd512 : (pick < 10) ? 10'sd511 :
                     (pick < 22) ? 10'($urandom) : 10'($urandom_range(0, 200) - 30);
        pick = $urandom_range(99);
        c.rect_width = (pick < 8) ? 9'd511 : (pick < 16) ? 9'd0 :
                       (pick < 26) ? 9'($urandom) : 9'($urandom_range(1, 160));
        pick = $urandom_range(99);
        c.rect_height = (pick < 8) ? 9'd511 : (pick < 16) ? 9'd0 :
                        (pick < 26) ? 9'($urandom) : 9'($urandom_range(1, 180));
        c.base_color = 8'($urandom);
        c.accent_color = 8'($urandom);
        pick = $urandom_range(99);
        c.row_stride = (pick < 55) ? 9'd144 : (pick < 65) ? 9'd256 :
                       (pick < 72) ? 9'd0 : (pick < 80) ? 9'd511 : 9'($urandom);
        return c;
    endfunction

    // Random register sets, each followed by a burst of pixels that mostly land on
    // or near the screen. The sender's idling rotates through three phases so gaps
    // fall on every pipeline stage, with gap-free stretches in between.
    task automatic test_random_fill();
        int target;
        int set_no;
        int burst;
        logic signed [10:0] x, y;
        target = pixels_sent + RANDOM_BEATS;
        set_no = 0;
        while (pixels_sent < target) begin
            load_config(random_fill_config());
            case (set_no % 3)
                0:       pixel_gap_pct = 0;
                1:       pixel_gap_pct = 47;
                default: pixel_gap_pct = 10;
            endcase
            burst = $urandom_range(10, 30);
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(99) < 15) begin
                    x = 11'($urandom);
                    y = 11'($urandom);
                end else begin
                    x = 11'($urandom_range(0, 150) - 3);
                    y = 11'($urandom_range(0, 174) - 3);
                end
                shade_pixel(x, y);
                // Midway through one set the sender waits out every pending result.
                if (set_no == 4 && i == burst / 2)
                    wait_pixels_done();
            end
            wait_pixels_done();
            set_no++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        err_count     = 0;
        cycle_count   = 0;
        pixels_sent   = 0;
        pixel_gap_pct = 0;
        fill_cfg      = CFG_RESET;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_pixel_x   <= '0;
        i_pixel_y   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_screen_clip();
        test_band_edges();
        test_odd_stride_and_modes();
        test_random_fill();

        wait_pixels_done();
        repeat (SETTLE) @(posedge i_clk);
        if (expected_writes.size() != 0)
            report_mismatch("pixels left without a result", expected_writes.size(), 0);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
